### design/graph_weighted_median_search_macros.svh
// Assertion macros used by the weighted median search controller.
`ifndef GRAPH_WEIGHTED_MEDIAN_SEARCH_MACROS_SVH
`define GRAPH_WEIGHTED_MEDIAN_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GWMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define GWMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gwms_pkg.sv
// Types, sizes and codes shared by the weighted median search modules.
`default_nettype none
package gwms_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned MAX_EDGES = 2048;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = NODE_W + 1;
  localparam int unsigned EIDX_W = $clog2(MAX_EDGES);
  localparam int unsigned FILL_W = EIDX_W + 1;
  localparam int unsigned IDX_W  = (EIDX_W > NODE_W) ? EIDX_W : NODE_W;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned WT_W   = 10;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned DIST_W = 20;
  localparam int unsigned PROD_W = WT_W + DIST_W;
  localparam int unsigned TOT_W  = 32;
  localparam int unsigned ACC_W  = TOT_W + 1;
  localparam int unsigned EDGE_W = 2 * NODE_W + LEN_W;

  localparam logic [WT_W-1:0]   WT_MAX   = '1;
  localparam logic [DIST_W-1:0] DIST_INF = '1;
  localparam logic [ACC_W-1:0]  ACC_SAT  = {1'b1, {TOT_W{1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_EDGE   = 2'd1,
    OP_START  = 2'd2
  } op_e;

  typedef struct packed {
    logic             wt_rd;
    logic             wt_wr;
    logic             edge_add;
    logic             edge_rd;
    logic             dist_init;
    logic             relax;
    logic             chg_clr;
    logic             sum_rd;
    logic             acc_clr;
    logic             best_init;
    logic             best_upd;
    logic             out_load;
    logic             clr_wr;
    logic             clr_fill;
    logic [IDX_W-1:0] idx;
    logic [NODE_W-1:0] src;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [FILL_W-1:0] fill;
    logic              changed;
    logic              edge_skip;
    logic              sum_busy;
    logic              out_busy;
  } stat_t;

endpackage
`default_nettype wire

### design/gwms_dp.sv
// Datapath: weight, edge and distance memories, relaxation, sum pipeline, result register.
`default_nettype none
module gwms_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gwms_pkg::cmd_t              cmd_i,
  input  logic [gwms_pkg::CNT_W-1:0]  node_a_i,
  input  logic [gwms_pkg::CNT_W-1:0]  node_b_i,
  input  logic [gwms_pkg::LEN_W-1:0]  edge_length_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gwms_pkg::CNT_W-1:0]  cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [gwms_pkg::TOT_W-1:0]  best_total_o,
  output logic                        overflow_o,
  output gwms_pkg::stat_t             stat_o
);
  import gwms_pkg::*;

  logic [CNT_W-1:0]  node_count_q;
  logic [CNT_W-1:0]  n;
  logic              a_ok, b_ok;
  logic [NODE_W-1:0] a_idx, b_idx;

  logic [WT_W-1:0]   wt_mem [MAX_NODES];
  logic [WT_W-1:0]   wt_rd_q;
  logic [NODE_W-1:0] wt_addr_q;
  logic              wt_ok_q;
  logic              wt_we;
  logic [NODE_W-1:0] wt_waddr, wt_raddr;
  logic [WT_W-1:0]   wt_wdata;

  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0] edge_q;
  logic [FILL_W-1:0] fill_q;
  logic              edge_we;
  logic [NODE_W-1:0] e_a, e_b;
  logic [LEN_W-1:0]  e_len;

  logic [DIST_W-1:0] dist_mem [MAX_NODES];
  logic [DIST_W-1:0] da_q, db_q;
  logic [NODE_W-1:0] dist_ra;
  logic              dist_we;
  logic [NODE_W-1:0] dist_waddr;
  logic [DIST_W-1:0] dist_wdata;
  logic [DIST_W:0]   nd_a, nd_b;
  logic              up_a, up_b;
  logic              changed_q;

  logic              v1_q, v2_q;
  logic [PROD_W-1:0] prod_q;
  logic              unr_q;
  logic [ACC_W-1:0]  acc_q, acc_sum, best_q;

  logic              out_valid_q;
  logic [TOT_W-1:0]  out_total_q;
  logic              out_ovf_q;

  assign cfg_ready_o = 1'b1;
  assign n = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;

  assign a_ok  = (node_a_i != '0) && (node_a_i <= CNT_W'(MAX_NODES));
  assign b_ok  = (node_b_i != '0) && (node_b_i <= CNT_W'(MAX_NODES));
  assign a_idx = node_a_i[NODE_W-1:0] - NODE_W'(1);
  assign b_idx = node_b_i[NODE_W-1:0] - NODE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(1);
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // Node weights: read-modify-write on load, zeroed by the clearing sweep.
  assign wt_we    = (cmd_i.wt_wr && wt_ok_q) || cmd_i.clr_wr;
  assign wt_waddr = cmd_i.clr_wr ? cmd_i.idx[NODE_W-1:0] : wt_addr_q;
  assign wt_wdata = cmd_i.clr_wr ? '0 :
                    ((wt_rd_q == WT_MAX) ? wt_rd_q : wt_rd_q + WT_W'(1));
  assign wt_raddr = cmd_i.sum_rd ? cmd_i.idx[NODE_W-1:0] : a_idx;

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    if (cmd_i.wt_rd || cmd_i.sum_rd) begin
      wt_rd_q <= wt_mem[wt_raddr];
    end
    if (cmd_i.wt_rd) begin
      wt_addr_q <= a_idx;
      wt_ok_q   <= a_ok;
    end
  end

  // Edge list, appended in arrival order.
  assign edge_we = cmd_i.edge_add && a_ok && b_ok && (fill_q < FILL_W'(MAX_EDGES));

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[fill_q[EIDX_W-1:0]] <= {edge_length_i, b_idx, a_idx};
    end
    if (cmd_i.edge_rd) begin
      edge_q <= edge_mem[cmd_i.idx[EIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.clr_fill) begin
      fill_q <= '0;
    end else if (edge_we) begin
      fill_q <= fill_q + FILL_W'(1);
    end
  end

  assign e_a   = edge_q[NODE_W-1:0];
  assign e_b   = edge_q[2*NODE_W-1:NODE_W];
  assign e_len = edge_q[EDGE_W-1:2*NODE_W];

  // Relax one undirected edge; at most one direction can improve.
  assign nd_a = {1'b0, da_q} + (DIST_W+1)'(e_len);
  assign nd_b = {1'b0, db_q} + (DIST_W+1)'(e_len);
  assign up_b = (da_q != DIST_INF) && (nd_a < {1'b0, db_q});
  assign up_a = (db_q != DIST_INF) && (nd_b < {1'b0, da_q});

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = cmd_i.idx[NODE_W-1:0];
    dist_wdata = (cmd_i.idx[NODE_W-1:0] == cmd_i.src) ? '0 : DIST_INF;
    if (cmd_i.dist_init) begin
      dist_we = 1'b1;
    end else if (cmd_i.relax && up_b) begin
      dist_we    = 1'b1;
      dist_waddr = e_b;
      dist_wdata = nd_a[DIST_W-1:0];
    end else if (cmd_i.relax && up_a) begin
      dist_we    = 1'b1;
      dist_waddr = e_a;
      dist_wdata = nd_b[DIST_W-1:0];
    end
  end

  assign dist_ra = cmd_i.sum_rd ? cmd_i.idx[NODE_W-1:0] : e_a;

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    da_q <= dist_mem[dist_ra];
    db_q <= dist_mem[e_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      changed_q <= 1'b0;
    end else if (cmd_i.chg_clr) begin
      changed_q <= 1'b0;
    end else if (cmd_i.relax && (up_a || up_b)) begin
      changed_q <= 1'b1;
    end
  end

  // Sum pipeline: memory read, multiply, saturating accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.sum_rd;
      v2_q <= v1_q;
    end
  end

  assign acc_sum = acc_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    unr_q  <= (wt_rd_q != '0) && (da_q == DIST_INF);
    prod_q <= (da_q == DIST_INF) ? '0 : PROD_W'(wt_rd_q) * PROD_W'(da_q);
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      if (unr_q || acc_q[TOT_W] || acc_sum[TOT_W]) begin
        acc_q <= ACC_SAT;
      end else begin
        acc_q <= acc_sum;
      end
    end
    if (cmd_i.best_init) begin
      best_q <= ACC_SAT;
    end else if (cmd_i.best_upd && (acc_q < best_q)) begin
      best_q <= acc_q;
    end
    if (cmd_i.out_load) begin
      out_total_q <= best_q[TOT_W] ? '1 : best_q[TOT_W-1:0];
      out_ovf_q   <= best_q[TOT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_total_o = out_total_q;
  assign overflow_o   = out_ovf_q;

  assign stat_o.n         = n;
  assign stat_o.fill      = fill_q;
  assign stat_o.changed   = changed_q;
  assign stat_o.edge_skip = ({1'b0, e_a} >= n) || ({1'b0, e_b} >= n);
  assign stat_o.sum_busy  = v1_q || v2_q;
  assign stat_o.out_busy  = out_valid_q;

endmodule
`default_nettype wire

### design/gwms_ctrl.sv
// Controller: sequences loading, per-source relaxation sweeps, summing and clearing.
`default_nettype none
`include "graph_weighted_median_search_macros.svh"
module gwms_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [gwms_pkg::OP_W-1:0]  opcode_i,
  output logic                       in_ready_o,
  input  gwms_pkg::stat_t            stat_i,
  output gwms_pkg::cmd_t             cmd_o
);
  import gwms_pkg::*;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WINC  = 4'd2;
  localparam logic [3:0] ST_SRC   = 4'd3;
  localparam logic [3:0] ST_DINIT = 4'd4;
  localparam logic [3:0] ST_SWEEP = 4'd5;
  localparam logic [3:0] ST_ERD   = 4'd6;
  localparam logic [3:0] ST_EDR   = 4'd7;
  localparam logic [3:0] ST_EDD   = 4'd8;
  localparam logic [3:0] ST_SEND  = 4'd9;
  localparam logic [3:0] ST_SUM   = 4'd10;
  localparam logic [3:0] ST_SUMW  = 4'd11;
  localparam logic [3:0] ST_NEXT  = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [NODE_W-1:0] src_q, src_d;
  logic [IDX_W:0]    idx_inc;
  logic [CNT_W-1:0]  src_inc;
  logic              node_end, edge_end, clr_end, src_end;

  assign idx_inc  = {1'b0, idx_q} + (IDX_W+1)'(1);
  assign src_inc  = {1'b0, src_q} + CNT_W'(1);
  assign node_end = idx_inc == (IDX_W+1)'(stat_i.n);
  assign edge_end = idx_inc == (IDX_W+1)'(stat_i.fill);
  assign clr_end  = idx_inc == (IDX_W+1)'(MAX_NODES);
  assign src_end  = src_inc == stat_i.n;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    src_d      = src_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    cmd_o.src  = src_q;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr_wr   = 1'b1;
        cmd_o.clr_fill = 1'b1;
        idx_d          = idx_inc[IDX_W-1:0];
        if (clr_end) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (opcode_i)
            OP_WEIGHT: begin
              cmd_o.wt_rd = 1'b1;
              state_d     = ST_WINC;
            end
            OP_EDGE:  cmd_o.edge_add = 1'b1;
            OP_START: state_d = ST_SRC;
            default: ;
          endcase
        end
      end
      ST_WINC: begin
        cmd_o.wt_wr = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SRC: begin
        cmd_o.best_init = 1'b1;
        src_d           = '0;
        idx_d           = '0;
        state_d         = (stat_i.n == '0) ? ST_DONE : ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.dist_init = 1'b1;
        cmd_o.acc_clr   = 1'b1;
        idx_d           = idx_inc[IDX_W-1:0];
        if (node_end) begin
          idx_d   = '0;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.chg_clr = 1'b1;
        idx_d         = '0;
        state_d       = (stat_i.fill == '0) ? ST_SUM : ST_ERD;
      end
      ST_ERD: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = ST_EDR;
      end
      ST_EDR: begin
        if (stat_i.edge_skip) begin
          idx_d   = idx_inc[IDX_W-1:0];
          state_d = edge_end ? ST_SEND : ST_ERD;
        end else begin
          state_d = ST_EDD;
        end
      end
      ST_EDD: begin
        cmd_o.relax = 1'b1;
        idx_d       = idx_inc[IDX_W-1:0];
        state_d     = edge_end ? ST_SEND : ST_ERD;
      end
      ST_SEND: begin
        // repeat the sweep until no distance moves
        idx_d   = '0;
        state_d = stat_i.changed ? ST_SWEEP : ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_rd = 1'b1;
        idx_d        = idx_inc[IDX_W-1:0];
        if (node_end) begin
          idx_d   = '0;
          state_d = ST_SUMW;
        end
      end
      ST_SUMW: begin
        if (!stat_i.sum_busy) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd_o.best_upd = 1'b1;
        idx_d          = '0;
        if (src_end) begin
          state_d = ST_DONE;
        end else begin
          src_d   = src_inc[NODE_W-1:0];
          state_d = ST_DINIT;
        end
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          idx_d          = '0;
          state_d        = ST_CLR;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      idx_q   <= '0;
      src_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      src_q   <= src_d;
    end
  end

  `GWMS_ASSERT_NXT(a_wt_rmw, cmd_o.wt_rd, cmd_o.wt_wr, "weight read not followed by write")
  `GWMS_ASSERT_IMP(a_out_free, cmd_o.out_load, !stat_i.out_busy, "result loaded over pending one")
  `GWMS_ASSERT_IMP(a_relax_ok, cmd_o.relax, !stat_i.edge_skip, "relaxing an edge out of range")
  `GWMS_ASSERT_IMP(a_fill_max, 1'b1, stat_i.fill <= FILL_W'(MAX_EDGES), "edge count overrun")

endmodule
`default_nettype wire

### design/graph_weighted_median_search.sv
// Channel   Dir  Payload (low bits first)                       Handshake
// s_axis    in   tuser: opcode; tdata: node_a, node_b, length    tvalid/tready
// m_axis    out  tuser: overflow; tdata: best_total              tvalid/tready
// cfg       in   cfg_data_i: node_count                          cfg_valid_i/cfg_ready_o
//
// After reset a sweep over all 1024 node weights zeroes them; no item is taken meanwhile.
// Weight items do a read-modify-write of the weight RAM; edge and unused items do not.
// Start: per source a distance init of the n nodes, then sweeps over the stored edges
// until no distance changes, then summing; then a clearing sweep over all 1024 weights.
// The result waits in an output register; a stalled output holds only the next result.
`default_nettype none
module graph_weighted_median_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // node_a[10:0], node_b[21:11], edge_length[29:22]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // best_total[31:0]
  output logic [0:0]  m_axis_tuser,   // overflow[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);
  import gwms_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign s_axis_tready = in_ready;

  gwms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gwms_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .node_a_i      (s_axis_tdata[10:0]),
    .node_b_i      (s_axis_tdata[21:11]),
    .edge_length_i (s_axis_tdata[29:22]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .best_total_o  (m_axis_tdata),
    .overflow_o    (m_axis_tuser[0]),
    .stat_o        (stat)
  );

endmodule
`default_nettype wire
